/* rtl/core/qrot_pkg.sv */
`timescale 1ns / 1ps
package qrot_pkg;

  localparam int QUAT_WIDTH_DEF  = 16;
  localparam int FIELD_WIDTH_DEF = 18;

  // fraction bits of the products and of the matrix entries
  localparam int MAT_FRAC = 27;
  // a product of two unit-range components lies in [-1, 1]
  localparam int PROD_W   = MAT_FRAC + 2;
  // diagonal entries lie in [-3, 1]*2^MAT_FRAC, off-diagonal ones in [-4, 4]*2^MAT_FRAC
  localparam int MAT_W    = MAT_FRAC + 4;

  localparam int CFG_IDX_W = 2;

  // items in flight from input register to output register
  localparam int PIPE_DEPTH = 6;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_NORTH = 2'd0,
    REG_EAST  = 2'd1,
    REG_DOWN  = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic signed [MAT_W-1:0] r00;
    logic signed [MAT_W-1:0] r01;
    logic signed [MAT_W-1:0] r02;
    logic signed [MAT_W-1:0] r10;
    logic signed [MAT_W-1:0] r11;
    logic signed [MAT_W-1:0] r12;
    logic signed [MAT_W-1:0] r20;
    logic signed [MAT_W-1:0] r21;
    logic signed [MAT_W-1:0] r22;
  } mat_t;

endpackage

/* rtl/core/qrot_in_if.sv */
`timescale 1ns / 1ps
interface qrot_in_if #(
  parameter int QUAT_WIDTH = qrot_pkg::QUAT_WIDTH_DEF
);
  logic                         valid;
  logic                         ready;
  logic signed [QUAT_WIDTH-1:0] quat_x;
  logic signed [QUAT_WIDTH-1:0] quat_y;
  logic signed [QUAT_WIDTH-1:0] quat_z;
  logic signed [QUAT_WIDTH-1:0] quat_w;

  modport source (output valid, output quat_x, output quat_y, output quat_z,
                  output quat_w, input ready);
  modport sink   (input valid, input quat_x, input quat_y, input quat_z,
                  input quat_w, output ready);
endinterface

/* rtl/core/qrot_out_if.sv */
`timescale 1ns / 1ps
interface qrot_out_if #(
  parameter int FIELD_WIDTH = qrot_pkg::FIELD_WIDTH_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [FIELD_WIDTH-1:0] body_x;
  logic signed [FIELD_WIDTH-1:0] body_y;
  logic signed [FIELD_WIDTH-1:0] body_z;

  modport source (output valid, output body_x, output body_y, output body_z,
                  input ready);
  modport sink   (input valid, input body_x, input body_y, input body_z,
                  output ready);
endinterface

/* rtl/core/quaternion_rotate_field_to_body.sv */
`timescale 1ns / 1ps
// Channel  Dir  Handshake           Payload
// in_ch    in   valid/ready         quat_x, quat_y, quat_z, quat_w (Q1.QUAT_WIDTH-1)
// out_ch   out  valid/ready         body_x, body_y, body_z (nT, saturated)
// cfg_*    in   cfg_we, no ready    cfg_index (0 north, 1 east, 2 down), cfg_data
//
// Six register stages; an item passes stages 1 to 6 in order and out_ch.valid
// is the stage-6 valid bit, so the result is offered straight from stage 6.
// One item per cycle sustained while out_ch is ready, set by the pipeline.
// The 31 x FIELD_WIDTH entry-times-field multipliers (stage 4) are the widest logic.
// Synchronous active-low reset clears valid bits and the field registers.
// A stall on out_ch backs up only as far as the first empty stage; bubbles close.
module quaternion_rotate_field_to_body #(
  parameter int QUAT_WIDTH  = qrot_pkg::QUAT_WIDTH_DEF,
  parameter int FIELD_WIDTH = qrot_pkg::FIELD_WIDTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  qrot_in_if.sink                            in_ch,
  qrot_out_if.source                         out_ch,
  input  logic                               cfg_we,
  input  logic [qrot_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic signed [FIELD_WIDTH-1:0]      cfg_data
);
  import qrot_pkg::*;

  // widths of the back half
  localparam int EPW = MAT_W + FIELD_WIDTH;        // entry * field
  localparam int AW  = EPW + 2;                    // sum of three
  localparam int VW  = AW - MAT_FRAC;              // after rounding shift
  localparam logic signed [AW-1:0] RND = AW'(1) <<< (MAT_FRAC - 1);
  localparam logic signed [VW-1:0] SAT_HI =
    {{(VW-FIELD_WIDTH+1){1'b0}}, {(FIELD_WIDTH-1){1'b1}}};
  localparam logic signed [VW-1:0] SAT_LO = ~SAT_HI;

  // earth field registers
  logic signed [FIELD_WIDTH-1:0] north_r, east_r, down_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      north_r <= '0;
      east_r  <= '0;
      down_r  <= '0;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_NORTH: north_r <= cfg_data;
        REG_EAST:  east_r  <= cfg_data;
        REG_DOWN:  down_r  <= cfg_data;
        default: ;  // unused index: write dropped
      endcase
    end
  end

  // stages 1-3: quaternion to matrix
  logic mat_valid, mat_ready;
  mat_t mat;

  qrot_matrix #(
    .QUAT_WIDTH (QUAT_WIDTH)
  ) u_matrix (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .quat_x    (in_ch.quat_x),
    .quat_y    (in_ch.quat_y),
    .quat_z    (in_ch.quat_z),
    .quat_w    (in_ch.quat_w),
    .mat_valid (mat_valid),
    .mat_ready (mat_ready),
    .mat       (mat)
  );

  // stages 4-6: R^T * E, round, saturate
  logic v4_r, v5_r, v6_r;
  logic en4, en5, en6;

  assign en6       = !v6_r || out_ch.ready;
  assign en5       = !v5_r || en6;
  assign en4       = !v4_r || en5;
  assign mat_ready = en4;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      v6_r <= 1'b0;
    end else begin
      if (en4) v4_r <= mat_valid;
      if (en5) v5_r <= v4_r;
      if (en6) v6_r <= v5_r;
    end
  end

  // row-major view of the matrix; column c of R feeds body component c
  logic signed [MAT_W-1:0]       m   [9];
  logic signed [FIELD_WIDTH-1:0] fld [3];
  logic signed [EPW-1:0]         fp_nxt [9];
  logic signed [EPW-1:0]         fp_r   [9];
  logic signed [AW-1:0]          acc_nxt [3];
  logic signed [AW-1:0]          acc_r   [3];
  logic signed [VW-1:0]          q       [3];
  logic signed [FIELD_WIDTH-1:0] body_nxt [3];
  logic signed [FIELD_WIDTH-1:0] body_r   [3];

  always_comb begin
    m[0] = mat.r00; m[1] = mat.r01; m[2] = mat.r02;
    m[3] = mat.r10; m[4] = mat.r11; m[5] = mat.r12;
    m[6] = mat.r20; m[7] = mat.r21; m[8] = mat.r22;
    fld[0] = north_r;
    fld[1] = east_r;
    fld[2] = down_r;
    // fp[3c+r] = R[r][c] * field[r]
    for (int c = 0; c < 3; c++) begin
      for (int r = 0; r < 3; r++) begin
        fp_nxt[3*c+r] = EPW'(m[3*r+c] * fld[r]);
      end
    end
  end

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      // rounding half folded into the sum
      acc_nxt[c] = AW'(fp_r[3*c]) + AW'(fp_r[3*c+1]) + AW'(fp_r[3*c+2]) + RND;
    end
  end

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      q[c] = VW'(acc_r[c] >>> MAT_FRAC);
      if (q[c] > SAT_HI) begin
        body_nxt[c] = SAT_HI[FIELD_WIDTH-1:0];
      end else if (q[c] < SAT_LO) begin
        body_nxt[c] = SAT_LO[FIELD_WIDTH-1:0];
      end else begin
        body_nxt[c] = q[c][FIELD_WIDTH-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en4) fp_r   <= fp_nxt;
    if (en5) acc_r  <= acc_nxt;
    if (en6) body_r <= body_nxt;
  end

  assign out_ch.valid  = v6_r;
  assign out_ch.body_x = body_r[0];
  assign out_ch.body_y = body_r[1];
  assign out_ch.body_z = body_r[2];

endmodule

/* rtl/core/qrot_matrix.sv */
`timescale 1ns / 1ps
// Quaternion to rotation matrix, three register stages:
// component products, rescale to MAT_FRAC, matrix entries.
module qrot_matrix #(
  parameter int QUAT_WIDTH = qrot_pkg::QUAT_WIDTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic signed [QUAT_WIDTH-1:0] quat_x,
  input  logic signed [QUAT_WIDTH-1:0] quat_y,
  input  logic signed [QUAT_WIDTH-1:0] quat_z,
  input  logic signed [QUAT_WIDTH-1:0] quat_w,
  output logic                         mat_valid,
  input  logic                         mat_ready,
  output qrot_pkg::mat_t               mat
);
  import qrot_pkg::*;

  localparam int PW = 2 * QUAT_WIDTH;
  localparam int PF = 2 * (QUAT_WIDTH - 1);

  localparam int XX = 0, YY = 1, ZZ = 2, XY = 3, XZ = 4, YZ = 5, WX = 6, WY = 7, WZ = 8;

  localparam logic signed [MAT_W-1:0] ONE = MAT_W'(1) <<< MAT_FRAC;

  logic                     v1_r, v2_r, v3_r;
  logic                     en1, en2, en3;
  logic signed [QUAT_WIDTH-1:0] opa [9];
  logic signed [QUAT_WIDTH-1:0] opb [9];
  logic signed [PW-1:0]     prod_nxt [9];
  logic signed [PW-1:0]     prod_r   [9];
  logic signed [PROD_W-1:0] scl_nxt  [9];
  logic signed [PROD_W-1:0] scl_r    [9];
  mat_t                     mat_nxt;
  mat_t                     mat_r;

  // stall chain: a stage loads when empty or when the next one loads
  assign en3       = !v3_r || mat_ready;
  assign en2       = !v2_r || en3;
  assign en1       = !v1_r || en2;
  assign in_ready  = en1;
  assign mat_valid = v3_r;
  assign mat       = mat_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (en1) v1_r <= in_valid;
      if (en2) v2_r <= v1_r;
      if (en3) v3_r <= v2_r;
    end
  end

  always_comb begin
    opa[XX] = quat_x; opb[XX] = quat_x;
    opa[YY] = quat_y; opb[YY] = quat_y;
    opa[ZZ] = quat_z; opb[ZZ] = quat_z;
    opa[XY] = quat_x; opb[XY] = quat_y;
    opa[XZ] = quat_x; opb[XZ] = quat_z;
    opa[YZ] = quat_y; opb[YZ] = quat_z;
    opa[WX] = quat_w; opb[WX] = quat_x;
    opa[WY] = quat_w; opb[WY] = quat_y;
    opa[WZ] = quat_w; opb[WZ] = quat_z;
    for (int k = 0; k < 9; k++) begin
      prod_nxt[k] = PW'(opa[k] * opb[k]);
    end
  end

  // rescale: round half up when there are too many fraction bits, else exact shift
  generate
    if (PF > MAT_FRAC) begin : g_round
      localparam int SH = PF - MAT_FRAC;
      localparam logic signed [PW:0] HALF = (PW+1)'(1) <<< (SH - 1);
      always_comb begin
        for (int k = 0; k < 9; k++) begin
          scl_nxt[k] = PROD_W'(((PW+1)'(prod_r[k]) + HALF) >>> SH);
        end
      end
    end else begin : g_shift
      localparam int SH = MAT_FRAC - PF;
      localparam int XW = PW + SH;
      always_comb begin
        for (int k = 0; k < 9; k++) begin
          scl_nxt[k] = PROD_W'(XW'(prod_r[k]) <<< SH);
        end
      end
    end
  endgenerate

  always_comb begin
    mat_nxt.r00 = ONE - ((MAT_W'(scl_r[YY]) + MAT_W'(scl_r[ZZ])) <<< 1);
    mat_nxt.r01 = (MAT_W'(scl_r[XY]) - MAT_W'(scl_r[WZ])) <<< 1;
    mat_nxt.r02 = (MAT_W'(scl_r[XZ]) + MAT_W'(scl_r[WY])) <<< 1;
    mat_nxt.r10 = (MAT_W'(scl_r[XY]) + MAT_W'(scl_r[WZ])) <<< 1;
    mat_nxt.r11 = ONE - ((MAT_W'(scl_r[XX]) + MAT_W'(scl_r[ZZ])) <<< 1);
    mat_nxt.r12 = (MAT_W'(scl_r[YZ]) - MAT_W'(scl_r[WX])) <<< 1;
    mat_nxt.r20 = (MAT_W'(scl_r[XZ]) - MAT_W'(scl_r[WY])) <<< 1;
    mat_nxt.r21 = (MAT_W'(scl_r[YZ]) + MAT_W'(scl_r[WX])) <<< 1;
    mat_nxt.r22 = ONE - ((MAT_W'(scl_r[XX]) + MAT_W'(scl_r[YY])) <<< 1);
  end

  always_ff @(posedge clk) begin
    if (en1) prod_r <= prod_nxt;
    if (en2) scl_r  <= scl_nxt;
    if (en3) mat_r  <= mat_nxt;
  end

endmodule

/* rtl/core/qrot_checker.sv */
`timescale 1ns / 1ps
module qrot_checker #(
  parameter int DEPTH = qrot_pkg::PIPE_DEPTH
) (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready
);
  localparam int CW = $clog2(DEPTH + 1) + 1;

  logic [CW-1:0] cnt_r;
  logic [CW-1:0] cnt_nxt;

  // items in flight
  always_comb begin
    cnt_nxt = cnt_r + CW'(in_valid && in_ready) - CW'(out_valid && out_ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> cnt_r != '0)
    else $error("result without a pending transfer");

  a_depth: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(DEPTH))
    else $error("more items in flight than pipeline stages");

  a_free_accept: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with an empty output register");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

endmodule

bind quaternion_rotate_field_to_body qrot_checker u_qrot_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready)
);

/* tb/quaternion_rotate_field_to_body_tb.sv */
`timescale 1ns / 1ps
module quaternion_rotate_field_to_body_tb;
  import qrot_pkg::*;

  localparam int QW = QUAT_WIDTH_DEF;
  localparam int FW = FIELD_WIDTH_DEF;
  // product of two Q1.15 values has 30 fraction bits; the matrix keeps MAT_FRAC
  localparam int PROD_SHIFT = 2 * (QW - 1) - MAT_FRAC;

  // index past the three field registers; writes to it must be dropped
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

  localparam int GAP_MAX         = 18;
  localparam int LONG_HOLD       = 120;
  localparam int FIELD_PHASES    = 9;
  localparam int ITEMS_PER_PHASE = 75;

  localparam logic signed [QW-1:0] Q_MAX  = 16'sh7fff;
  localparam logic signed [QW-1:0] Q_MIN  = 16'sh8000;
  localparam logic signed [QW-1:0] Q_ZERO = 16'sd0;
  localparam logic signed [QW-1:0] Q_ONE  = 16'sd1;
  localparam logic signed [QW-1:0] Q_NEG1 = -16'sd1;
  localparam logic signed [QW-1:0] Q_HALF = 16'sd16384;
  localparam logic signed [QW-1:0] Q_NHLF = -16'sd16384;
  localparam logic signed [QW-1:0] Q_R2   = 16'sd23170;   // cos(45 deg)

  localparam logic signed [FW-1:0] FIELD_MAX = {1'b0, {(FW-1){1'b1}}};
  localparam logic signed [FW-1:0] FIELD_MIN = {1'b1, {(FW-1){1'b0}}};
  localparam logic signed [FW-1:0] FIELD_LIM = 18'sd100000;

  typedef struct packed {
    logic signed [QW-1:0] x;
    logic signed [QW-1:0] y;
    logic signed [QW-1:0] z;
    logic signed [QW-1:0] w;
  } quat_t;

  typedef struct packed {
    logic signed [FW-1:0] bx;
    logic signed [FW-1:0] by;
    logic signed [FW-1:0] bz;
  } body_t;

  // Holds the earth field as the block should see it and the queue of body
  // vectors owed by the block, oldest first.
  class body_field_scoreboard;
    longint north;
    longint east;
    longint down;
    body_t  expected_bodies[$];
    int     errors;

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic signed [FW-1:0] value);
      case (idx)
        REG_NORTH: north = value;
        REG_EAST:  east  = value;
        REG_DOWN:  down  = value;
        default: ;
      endcase
    endfunction

    // q * q at MAT_FRAC fraction bits, rounded half up
    static function longint scaled_prod(longint a, longint b);
      return (a * b + (64'sd1 <<< (PROD_SHIFT - 1))) >>> PROD_SHIFT;
    endfunction

    static function logic signed [FW-1:0] to_nanotesla(longint acc);
      longint v;
      v = (acc + (64'sd1 <<< (MAT_FRAC - 1))) >>> MAT_FRAC;
      if (v > longint'(FIELD_MAX)) v = FIELD_MAX;
      if (v < longint'(FIELD_MIN)) v = FIELD_MIN;
      return v[FW-1:0];
    endfunction

    function void note_input(quat_t q);
      longint x, y, z, w, one;
      longint sxx, syy, szz, sxy, sxz, syz, swx, swy, swz;
      longint r00, r01, r02, r10, r11, r12, r20, r21, r22;
      body_t  b;
      x = $signed(q.x);
      y = $signed(q.y);
      z = $signed(q.z);
      w = $signed(q.w);
      one = 64'sd1 <<< MAT_FRAC;
      sxx = scaled_prod(x, x);
      syy = scaled_prod(y, y);
      szz = scaled_prod(z, z);
      sxy = scaled_prod(x, y);
      sxz = scaled_prod(x, z);
      syz = scaled_prod(y, z);
      swx = scaled_prod(w, x);
      swy = scaled_prod(w, y);
      swz = scaled_prod(w, z);
      r00 = one - 2 * (syy + szz);
      r01 = 2 * (sxy - swz);
      r02 = 2 * (sxz + swy);
      r10 = 2 * (sxy + swz);
      r11 = one - 2 * (sxx + szz);
      r12 = 2 * (syz - swx);
      r20 = 2 * (sxz - swy);
      r21 = 2 * (syz + swx);
      r22 = one - 2 * (sxx + syy);
      // body = R^T * earth
      b.bx = to_nanotesla(r00 * north + r10 * east + r20 * down);
      b.by = to_nanotesla(r01 * north + r11 * east + r21 * down);
      b.bz = to_nanotesla(r02 * north + r12 * east + r22 * down);
      expected_bodies.push_back(b);
    endfunction

    task flag_mismatch(string msg);
      errors++;
      $display("[%0t] ERROR: %s", $time, msg);
    endtask

    task check_result(body_t got);
      body_t want;
      if (expected_bodies.size() == 0) begin
        flag_mismatch($sformatf("body vector (%0d, %0d, %0d) with no transfer pending",
                                $signed(got.bx), $signed(got.by), $signed(got.bz)));
        return;
      end
      want = expected_bodies.pop_front();
      if (got.bx !== want.bx)
        flag_mismatch($sformatf("body_x got %0d expected %0d",
                                $signed(got.bx), $signed(want.bx)));
      if (got.by !== want.by)
        flag_mismatch($sformatf("body_y got %0d expected %0d",
                                $signed(got.by), $signed(want.by)));
      if (got.bz !== want.bz)
        flag_mismatch($sformatf("body_z got %0d expected %0d",
                                $signed(got.bz), $signed(want.bz)));
    endtask

    function int pending_count();
      return expected_bodies.size();
    endfunction
  endclass

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic signed [FW-1:0] cfg_data;

  qrot_in_if  #(.QUAT_WIDTH(QW))  quat_ch ();
  qrot_out_if #(.FIELD_WIDTH(FW)) body_ch ();

  quaternion_rotate_field_to_body #(
    .QUAT_WIDTH  (QW),
    .FIELD_WIDTH (FW)
  ) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (quat_ch),
    .out_ch    (body_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  body_field_scoreboard body_board;

  int quats_sent;
  int bodies_taken;
  int burst_items;        // sender transfers left with no gap at all
  bit long_hold_req;      // asks the receiver for one long stall

  logic signed [QW-1:0] corner_vals [5] = '{Q_MIN, Q_NEG1, Q_ZERO, Q_ONE, Q_MAX};

  // Directed attitudes: identity in both signs, the zero quaternion, each axis
  // at both extremes, all-max / all-min and alternating extremes (heavily
  // unnormalized, drives saturation), 90 deg turns about each axis, two 120 deg
  // turns about body diagonals, and the smallest nonzero values.
  quat_t directed_quats [20] = '{
    '{Q_ZERO, Q_ZERO, Q_ZERO, Q_MAX},
    '{Q_ZERO, Q_ZERO, Q_ZERO, Q_MIN},
    '{Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO},
    '{Q_MAX,  Q_ZERO, Q_ZERO, Q_ZERO},
    '{Q_ZERO, Q_MAX,  Q_ZERO, Q_ZERO},
    '{Q_ZERO, Q_ZERO, Q_MAX,  Q_ZERO},
    '{Q_MIN,  Q_ZERO, Q_ZERO, Q_ZERO},
    '{Q_ZERO, Q_MIN,  Q_ZERO, Q_ZERO},
    '{Q_ZERO, Q_ZERO, Q_MIN,  Q_ZERO},
    '{Q_MAX,  Q_MAX,  Q_MAX,  Q_MAX},
    '{Q_MIN,  Q_MIN,  Q_MIN,  Q_MIN},
    '{Q_MAX,  Q_MIN,  Q_MAX,  Q_MIN},
    '{Q_MIN,  Q_MAX,  Q_MIN,  Q_MAX},
    '{Q_ZERO, Q_ZERO, Q_R2,   Q_R2},
    '{Q_R2,   Q_ZERO, Q_ZERO, Q_R2},
    '{Q_ZERO, Q_R2,   Q_ZERO, Q_R2},
    '{Q_HALF, Q_HALF, Q_HALF, Q_HALF},
    '{Q_NHLF, Q_HALF, Q_NHLF, Q_HALF},
    '{Q_NEG1, Q_NEG1, Q_NEG1, Q_NEG1},
    '{Q_ONE,  Q_ONE,  Q_ONE,  Q_ONE}
  };

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop, set beyond the slowest legal run: every item with the longest gap
  // and stall, plus the drains and the long hold.
  initial begin
    #5_000_000;
    $display("simulation failed");
    $finish;
  end

  // Random attitude: half near-unit (the real use case), the rest full-range
  // noise or picks from the corner values.
  function automatic quat_t random_quat();
    quat_t q;
    real   a [4];
    real   norm;
    int    kind;
    kind = $urandom_range(0, 9);
    q    = '{Q_ZERO, Q_ZERO, Q_ZERO, Q_MAX};
    if (kind < 5) begin
      norm = 0.0;
      foreach (a[i]) begin
        a[i] = real'(int'($urandom_range(0, 65534)) - 32767);
        norm += a[i] * a[i];
      end
      norm = $sqrt(norm);
      if (norm >= 1.0) begin
        q.x = QW'($rtoi(a[0] / norm * 32767.0));
        q.y = QW'($rtoi(a[1] / norm * 32767.0));
        q.z = QW'($rtoi(a[2] / norm * 32767.0));
        q.w = QW'($rtoi(a[3] / norm * 32767.0));
      end
    end else if (kind < 8) begin
      q = {$urandom, $urandom};
    end else begin
      q.x = corner_vals[$urandom_range(0, 4)];
      q.y = corner_vals[$urandom_range(0, 4)];
      q.z = corner_vals[$urandom_range(0, 4)];
      q.w = corner_vals[$urandom_range(0, 4)];
    end
    return q;
  endfunction

  // One transfer on the quaternion channel. valid stays up across back-to-back
  // items; it only drops when a gap is drawn, so it never gets two updates in
  // one step.
  task automatic send_quat(input quat_t q);
    int gap;
    if (burst_items > 0) begin
      gap = 0;
      burst_items--;
    end else if (quats_sent % 60 < 15) begin
      gap = 0;
    end else begin
      gap = $urandom_range(0, GAP_MAX);
    end
    if (gap > 0) begin
      quat_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    quat_ch.valid  <= 1'b1;
    quat_ch.quat_x <= q.x;
    quat_ch.quat_y <= q.y;
    quat_ch.quat_z <= q.z;
    quat_ch.quat_w <= q.w;
    @(posedge clk);
    while (!quat_ch.ready) @(posedge clk);
    body_board.note_input(q);
    quats_sent++;
  endtask

  // Stop offering and wait until every owed body vector is back, then keep
  // waiting so a stray extra result would still be caught.
  task automatic wait_drained();
    quat_ch.valid <= 1'b0;
    while (body_board.pending_count() > 0) @(posedge clk);
    repeat (PIPE_DEPTH + 4) @(posedge clk);
  endtask

  // Field load, only while the pipe is empty. The spare index gets junk that
  // must not land anywhere. cfg_we stays high across the four writes.
  task automatic load_field(input logic signed [FW-1:0] n,
                            input logic signed [FW-1:0] e,
                            input logic signed [FW-1:0] d);
    logic [CFG_IDX_W-1:0] idx [4];
    logic signed [FW-1:0] val [4];
    idx = '{REG_NORTH, REG_EAST, REG_DOWN, REG_SPARE};
    val = '{n, e, d, FW'($urandom)};
    for (int i = 0; i < 4; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= idx[i];
      cfg_data  <= val[i];
      @(posedge clk);
      body_board.set_reg(idx[i], val[i]);
    end
    cfg_we <= 1'b0;
  endtask

  // Receiver: stalls a drawn number of cycles before each transfer, with
  // no-stall stretches, and one long hold on request so the pipe backs up.
  task automatic collect_bodies();
    int stall;
    forever begin
      if (long_hold_req) begin
        stall = LONG_HOLD;
        long_hold_req = 1'b0;
      end else if (bodies_taken % 50 < 15) begin
        stall = 0;
      end else begin
        stall = $urandom_range(0, GAP_MAX);
      end
      if (stall > 0) begin
        body_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      body_ch.ready <= 1'b1;
      @(posedge clk);
      while (!body_ch.valid) @(posedge clk);
      body_board.check_result('{body_ch.body_x, body_ch.body_y, body_ch.body_z});
      bodies_taken++;
    end
  endtask

  // Field setting for each random phase: a typical field, both rails of the
  // register, both ends of the intended range, mixed rails, then random ones.
  task automatic load_phase_field(input int phase);
    case (phase)
      0: load_field(18'sd21000, 18'sd1500, 18'sd43000);
      1: load_field(FIELD_MAX, FIELD_MAX, FIELD_MAX);
      2: load_field(FIELD_MIN, FIELD_MIN, FIELD_MIN);
      3: load_field(FIELD_LIM, -FIELD_LIM, FIELD_LIM);
      4: load_field(-FIELD_LIM, FIELD_LIM, -FIELD_LIM);
      5: load_field(FIELD_MAX, FIELD_MIN, 18'sd0);
      7: load_field(FW'($urandom), FW'($urandom), FW'($urandom));
      default: load_field(FW'($urandom_range(0, 200000)) - FIELD_LIM,
                          FW'($urandom_range(0, 200000)) - FIELD_LIM,
                          FW'($urandom_range(0, 200000)) - FIELD_LIM);
    endcase
  endtask

  initial begin
    body_board     = new;
    quats_sent     = 0;
    bodies_taken   = 0;
    burst_items    = 0;
    long_hold_req  = 1'b0;
    rst_n          <= 1'b0;
    cfg_we         <= 1'b0;
    cfg_index      <= REG_NORTH;
    cfg_data       <= '0;
    quat_ch.valid  <= 1'b0;
    quat_ch.quat_x <= '0;
    quat_ch.quat_y <= '0;
    quat_ch.quat_z <= '0;
    quat_ch.quat_w <= '0;
    body_ch.ready  <= 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    fork
      collect_bodies();
    join_none

    // field registers straight out of reset: every body vector is zero
    send_quat(directed_quats[0]);
    send_quat(directed_quats[9]);
    send_quat(random_quat());
    wait_drained();

    // directed attitudes under a plain mid-latitude field
    load_field(18'sd20000, -18'sd3000, 18'sd45000);
    foreach (directed_quats[i]) send_quat(directed_quats[i]);
    wait_drained();

    for (int phase = 0; phase < FIELD_PHASES; phase++) begin
      load_phase_field(phase);
      for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
        // back-to-back offers while the receiver sits out: pipe fills, in_ch stalls
        if (phase == 3 && k == 20) begin
          long_hold_req = 1'b1;
          burst_items   = 40;
        end
        // sender pauses until everything in flight has come back
        if (phase == 5 && k == 40) wait_drained();
        send_quat(random_quat());
      end
      wait_drained();
    end

    if (body_board.errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/core/qrot_pkg.sv
rtl/core/qrot_in_if.sv
rtl/core/qrot_out_if.sv
rtl/core/qrot_matrix.sv
rtl/core/quaternion_rotate_field_to_body.sv
rtl/core/qrot_checker.sv
tb/quaternion_rotate_field_to_body_tb.sv
